@@ hdl/frlp_pkg.sv @@
package frlp_pkg;

  localparam int MAX_FRAMES  = 64;
  localparam int MARK_W      = 64;
  localparam int IDX_W       = 6;
  localparam int COUNT_W     = 7;
  localparam int VALUE_W     = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic [COUNT_W-1:0] USABLE_MAX = COUNT_W'((MAX_FRAMES < MARK_W) ?
                                                       MAX_FRAMES : MARK_W);

  // result status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_BAD_NUMBER   = 3'd1;
  localparam logic [2:0] ST_BAD_RANGE    = 3'd2;
  localparam logic [2:0] ST_REVERSE      = 3'd3;
  localparam logic [2:0] ST_OUT_OF_RANGE = 3'd4;
  localparam logic [2:0] ST_NO_FRAMES    = 3'd5;

  // position within a token
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_NUM1  = 3'd1;
  localparam logic [2:0] PH_GAP1  = 3'd2;
  localparam logic [2:0] PH_DASH  = 3'd3;
  localparam logic [2:0] PH_NUM2  = 3'd4;
  localparam logic [2:0] PH_GAP2  = 3'd5;

  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [7:0] char_code;
    logic       no_char;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             has_index;
    logic [IDX_W-1:0] frame_index;
    logic             last_result;
  } out_item_t;

  // one finished spec handed from the parser to the emitter
  typedef struct packed {
    logic [2:0]        status;
    logic [MARK_W-1:0] marks;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_STATUS
  } back_state_t;

endpackage

@@ hdl/frlp_queue.sv @@
module frlp_queue import frlp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output job_t pop_data,
  output logic full,
  output logic empty
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full     = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/frlp_front.sv @@
module frlp_front import frlp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  in_item_t           in_data,
  output logic               in_stall,
  input  logic [COUNT_W-1:0] frame_count,
  input  logic               q_full,
  output logic               q_push,
  output job_t               q_data
);

  logic [MARK_W-1:0]  marks_r, marks_nxt;
  logic [VALUE_W-1:0] v1_r, v1_nxt;
  logic [VALUE_W-1:0] v2_r, v2_nxt;
  logic [2:0]         phase_r, phase_nxt;
  logic               bad1_r, bad1_nxt;
  logic               bad2_r, bad2_nxt;
  logic               dash2_r, dash2_nxt;
  logic               dig1_r, dig1_nxt;
  logic [2:0]         err_r, err_nxt;
  logic               any_r, any_nxt;
  logic               fin_r, fin_nxt;

  logic               accept;
  logic [7:0]         c;
  logic               is_digit;
  logic [3:0]         digit;
  logic [VALUE_W-1:0] acc;
  logic [VALUE_W+3:0] prod;
  logic               ovf;

  logic [COUNT_W-1:0] usable;
  logic [2:0]         fin_err;
  logic               fin_mark;
  logic [VALUE_W-1:0] lo, hi;
  logic [IDX_W-1:0]   lo_sh;
  logic [COUNT_W-1:0] hi_sh;
  logic [MARK_W-1:0]  fin_mask;

  logic [2:0]         job_err;
  logic [2:0]         job_status;
  logic [MARK_W-1:0]  job_marks;

  assign in_stall = fin_r || q_full;
  assign accept   = in_valid && !in_stall;
  assign c        = in_data.char_code;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit    = 4'(c - CH_ZERO);
  assign usable   = (frame_count > USABLE_MAX) ? USABLE_MAX : frame_count;

  // one shared multiply-by-ten for whichever part is being accumulated
  assign acc  = (phase_r <= PH_NUM1) ? v1_r : v2_r;
  assign prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (VALUE_W+4)'(digit);
  assign ovf  = |prod[VALUE_W+3:VALUE_W];

  // judge the token held in the registers
  always_comb begin
    fin_err  = ST_OK;
    fin_mark = 1'b0;
    lo       = v1_r;
    hi       = v1_r;
    if (phase_r < PH_DASH) begin
      if (bad1_r) begin
        fin_err = ST_BAD_NUMBER;
      end else if (phase_r != PH_START) begin
        fin_mark = 1'b1;
      end
    end else begin
      hi = v2_r;
      if (bad1_r || bad2_r || dash2_r || !dig1_r || phase_r == PH_DASH) begin
        fin_err = ST_BAD_RANGE;
      end else if (v1_r > v2_r) begin
        fin_err = ST_REVERSE;
      end else begin
        fin_mark = 1'b1;
      end
    end
    if (fin_mark && (lo == '0 || hi > VALUE_W'(usable))) begin
      fin_err  = ST_OUT_OF_RANGE;
      fin_mark = 1'b0;
    end
  end

  assign lo_sh    = IDX_W'(lo[COUNT_W-1:0] - 1'b1);
  assign hi_sh    = COUNT_W'(COUNT_W'(MARK_W) - hi[COUNT_W-1:0]);
  assign fin_mask = ({MARK_W{1'b1}} << lo_sh) & ({MARK_W{1'b1}} >> hi_sh);

  // close the spec: final token, zero frame count override
  always_comb begin
    job_err   = (err_r != ST_OK) ? err_r : fin_err;
    job_marks = marks_r | ((err_r == ST_OK && fin_mark) ? fin_mask : '0);
    if (frame_count == '0) begin
      job_status = any_r ? ST_NO_FRAMES : ST_OK;
    end else begin
      job_status = job_err;
    end
    q_data.status = job_status;
    q_data.marks  = (job_status == ST_OK && frame_count != '0) ? job_marks : '0;
  end

  assign q_push = fin_r && !q_full;

  always_comb begin
    marks_nxt = marks_r;
    v1_nxt    = v1_r;
    v2_nxt    = v2_r;
    phase_nxt = phase_r;
    bad1_nxt  = bad1_r;
    bad2_nxt  = bad2_r;
    dash2_nxt = dash2_r;
    dig1_nxt  = dig1_r;
    err_nxt   = err_r;
    any_nxt   = any_r;
    fin_nxt   = fin_r;
    if (q_push) begin
      marks_nxt = '0;
      v1_nxt    = '0;
      v2_nxt    = '0;
      phase_nxt = PH_START;
      bad1_nxt  = 1'b0;
      bad2_nxt  = 1'b0;
      dash2_nxt = 1'b0;
      dig1_nxt  = 1'b0;
      err_nxt   = ST_OK;
      any_nxt   = 1'b0;
      fin_nxt   = 1'b0;
    end else if (accept) begin
      fin_nxt = in_data.last_char;
      if (!in_data.no_char) begin
        any_nxt = 1'b1;
        if (err_r == ST_OK) begin
          if (c == CH_COMMA) begin
            err_nxt = fin_err;
            if (fin_mark) begin
              marks_nxt = marks_r | fin_mask;
            end
            v1_nxt    = '0;
            v2_nxt    = '0;
            phase_nxt = PH_START;
            bad1_nxt  = 1'b0;
            bad2_nxt  = 1'b0;
            dash2_nxt = 1'b0;
            dig1_nxt  = 1'b0;
          end else if (c == CH_DASH) begin
            if (phase_r < PH_DASH) begin
              phase_nxt = PH_DASH;
            end else begin
              dash2_nxt = 1'b1;
            end
          end else if (c == CH_SPACE || c == CH_TAB) begin
            if (phase_r == PH_NUM1) begin
              phase_nxt = PH_GAP1;
            end else if (phase_r == PH_NUM2) begin
              phase_nxt = PH_GAP2;
            end
          end else if (is_digit) begin
            if (phase_r <= PH_NUM1) begin
              dig1_nxt  = 1'b1;
              phase_nxt = PH_NUM1;
              if (!bad1_r) begin
                if (ovf) begin
                  bad1_nxt = 1'b1;
                end else begin
                  v1_nxt = prod[VALUE_W-1:0];
                end
              end
            end else if (phase_r == PH_GAP1) begin
              bad1_nxt = 1'b1;
            end else if (phase_r <= PH_NUM2) begin
              phase_nxt = PH_NUM2;
              if (!bad2_r) begin
                if (ovf) begin
                  bad2_nxt = 1'b1;
                end else begin
                  v2_nxt = prod[VALUE_W-1:0];
                end
              end
            end else begin
              bad2_nxt = 1'b1;
            end
          end else if (phase_r < PH_DASH) begin
            bad1_nxt = 1'b1;
          end else begin
            bad2_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r <= '0;
      v1_r    <= '0;
      v2_r    <= '0;
      phase_r <= PH_START;
      bad1_r  <= 1'b0;
      bad2_r  <= 1'b0;
      dash2_r <= 1'b0;
      dig1_r  <= 1'b0;
      err_r   <= ST_OK;
      any_r   <= 1'b0;
      fin_r   <= 1'b0;
    end else begin
      marks_r <= marks_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v2_nxt;
      phase_r <= phase_nxt;
      bad1_r  <= bad1_nxt;
      bad2_r  <= bad2_nxt;
      dash2_r <= dash2_nxt;
      dig1_r  <= dig1_nxt;
      err_r   <= err_nxt;
      any_r   <= any_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

@@ hdl/frlp_back.sv @@
module frlp_back import frlp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  job_t      q_data,
  output logic      q_pop,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);

  back_state_t       state_r, state_nxt;
  logic [MARK_W-1:0] sh_r, sh_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [2:0]        st_r, st_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              out_free;
  logic              rest;
  logic              out_load;

  assign out_free  = !out_valid_r || !out_stall;
  assign rest      = |sh_r[MARK_W-1:1];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_data.marks != '0) ? BK_SCAN : BK_STATUS;
        end
      end
      BK_SCAN: begin
        if (sh_r[0] && out_free && !rest) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_STATUS: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    sh_nxt       = sh_r;
    idx_nxt      = idx_r;
    st_nxt       = st_r;
    out_load     = 1'b0;
    out_data_nxt = out_data_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          sh_nxt  = q_data.marks;
          idx_nxt = '0;
          st_nxt  = q_data.status;
        end
      end
      BK_SCAN: begin
        // advance past an empty position, or a marked one once it can go out
        if (!sh_r[0] || out_free) begin
          sh_nxt  = sh_r >> 1;
          idx_nxt = idx_r + 1'b1;
        end
        if (sh_r[0] && out_free) begin
          out_load                 = 1'b1;
          out_data_nxt.status      = ST_OK;
          out_data_nxt.has_index   = 1'b1;
          out_data_nxt.frame_index = idx_r;
          out_data_nxt.last_result = !rest;
        end
      end
      BK_STATUS: begin
        if (out_free) begin
          out_load                 = 1'b1;
          out_data_nxt.status      = st_r;
          out_data_nxt.has_index   = 1'b0;
          out_data_nxt.frame_index = '0;
          out_data_nxt.last_result = 1'b1;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    idx_r      <= idx_nxt;
    st_r       <= st_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ hdl/frame_range_list_parser_unit.sv @@
// Frame range list parser. Takes a spec such as "1-3, 7,9" one character per
// transfer and, on the item flagged last_char, returns the selected frames as
// ascending 0-based indices or a single status result. Characters are taken
// at one per cycle while the queue is not full; after the item carrying
// last_char the input stalls while the final token is judged and until the
// spec is handed to a two-entry queue. The emitter pops a spec from the queue
// and then walks the 64-bit frame bitmap one position per cycle, holding at a
// marked position while the output is stalled, while the parser already
// takes the characters of the next spec.
// frame_count is written through the cfg_ port; the user must write it only
// while no spec is in flight, as the block itself does not enforce this.
module frame_range_list_parser_unit import frlp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  in_item_t           in_data,
  output logic               in_stall,
  output logic               out_valid,
  output out_item_t          out_data,
  input  logic               out_stall,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  logic [COUNT_W-1:0] frame_count_r;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  job_t               q_wdata;
  job_t               q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      frame_count_r <= cfg_data;
    end
  end

  frlp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .in_stall    (in_stall),
    .frame_count (frame_count_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  frlp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  frlp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("spec queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty))
    else $error("spec queue read while empty");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.has_index) |-> out_data.last_result)
    else $error("status result not marked last");

  a_index_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.has_index) |-> (out_data.status == ST_OK))
    else $error("frame index sent with error status");
`endif

endmodule
